FILE: rtl/g2e_pkg.sv
// Package: shared constants, types and fixed-point helpers for the geodetic to ENU pipeline.
`default_nettype none

package g2e_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int FRAC_BITS     = 30;
  // sin, cos and angle width: covers just under +-8 radians, sign included
  localparam int CW            = FRAC_BITS + 4;

  // latencies in register stages
  localparam int SC_LAT    = CORDIC_STAGES + 4;
  localparam int ECEF_POST = 58;
  localparam int ECEF_LAT  = SC_LAT + ECEF_POST;
  localparam int ROT_LAT   = 8;
  localparam int TOTAL_LAT = ECEF_LAT + ROT_LAT;

  localparam int OUT_W = 36;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 112;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_IN_ERR  = 2'd1;
  localparam logic [1:0] STAT_REF_ERR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_REF_LAT = 2'd0;
  localparam logic [1:0] CFG_REF_LON = 2'd1;
  localparam logic [1:0] CFG_REF_ALT = 2'd2;

  // angle limits in 1e-7 degree
  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LAT_MIN = -32'sd900000000;
  localparam logic signed [31:0] LON_MIN = -32'sd1800000000;

  localparam logic [63:0] ONE62      = 64'd1 << 62;
  localparam logic [63:0] THREE62    = 64'd3 << 62;
  localparam logic [63:0] A_EARTH_MM = 64'd6378137000;
  localparam logic [63:0] INVF_NUM   = 64'd298257223563;
  localparam logic [63:0] INVF_DEN   = 64'd1000000000;
  localparam logic [63:0] DEG7_PI    = 64'd1800000000;
  localparam logic [63:0] INT64_MAX  = {1'b0, {63{1'b1}}};

  // four 32x32 partial products of a 64x64 unsigned multiply
  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } mparts_t;

  // signed multiply in flight: magnitude partials and result sign
  typedef struct packed {
    mparts_t p;
    logic    neg;
  } smp_t;

  // sines and cosines of one point
  typedef struct packed {
    logic signed [CW-1:0] s_lat;
    logic signed [CW-1:0] c_lat;
    logic signed [CW-1:0] s_lon;
    logic signed [CW-1:0] c_lon;
  } trig_t;

  typedef logic [CORDIC_STAGES-1:0][CW-1:0] atab_t;

  function automatic mparts_t mul_parts(logic [63:0] a, logic [63:0] b);
    mparts_t r;
    r.ll = 64'(a[31:0]) * 64'(b[31:0]);
    r.lh = 64'(a[31:0]) * 64'(b[63:32]);
    r.hl = 64'(a[63:32]) * 64'(b[31:0]);
    r.hh = 64'(a[63:32]) * 64'(b[63:32]);
    return r;
  endfunction

  // sum the partials, round to nearest at the shift point, keep 64 bits
  function automatic logic [63:0] mul_comb(mparts_t p, int unsigned sh);
    logic [127:0] s;
    s = {64'd0, p.ll} + ({64'd0, p.lh} << 32) + ({64'd0, p.hl} << 32) + {p.hh, 64'd0};
    if (sh != 0) begin
      s = s + (128'd1 << (sh - 1));
    end
    s = s >> sh;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sabs(logic signed [63:0] v);
    return v[63] ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic smp_t smul_parts(logic signed [63:0] a, logic signed [63:0] b);
    smp_t r;
    r.neg = a[63] ^ b[63];
    r.p   = mul_parts(sabs(a), sabs(b));
    return r;
  endfunction

  function automatic logic signed [63:0] smul_comb(smp_t r, int unsigned sh);
    logic [63:0] m;
    m = mul_comb(r.p, sh);
    if (m > INT64_MAX) begin
      m = INT64_MAX;
    end
    return r.neg ? $signed(64'd0 - m) : $signed(m);
  endfunction

  // ---- elaboration-time constant generation ----

  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] umod(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] umulsh(logic [63:0] a, logic [63:0] b, int unsigned sh);
    return mul_comb(mul_parts(a, b), sh);
  endfunction

  function automatic logic [63:0] to_f(logic [63:0] v);
    return (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] atan_inv(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] t;
    p = udiv(ONE62, n);
    s = '0;
    k = '0;
    for (int it = 0; it < 64; it++) begin
      if (p != 0) begin
        t = udiv(p, 2 * k + 1);
        if (k[0]) s = s - t;
        else s = s + t;
        p = udiv(p, n * n);
        k = k + 1;
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] calc_pi62();
    return 64'd16 * atan_inv(64'd5) - 64'd4 * atan_inv(64'd239);
  endfunction

  localparam logic [63:0] PI62 = calc_pi62();

  function automatic atab_t gen_atan();
    atab_t       tab;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] t;
    int          sh;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        tab[i] = CW'(to_f(PI62 >> 2));
      end else begin
        p  = (i < 62) ? (64'd1 << (62 - i)) : 64'd0;
        s  = '0;
        k  = '0;
        sh = 2 * i;
        for (int it = 0; it < 64; it++) begin
          if (p != 0) begin
            t = udiv(p, 2 * k + 1);
            if (k[0]) s = s - t;
            else s = s + t;
            p = (sh < 64) ? (p >> sh) : 64'd0;
            k = k + 1;
          end
        end
        tab[i] = CW'(to_f(s));
      end
    end
    return tab;
  endfunction

  function automatic logic [63:0] rsqrt62(logic [63:0] a, logic [63:0] y0);
    logic [63:0] y;
    logic [63:0] t;
    y = y0;
    for (int k = 0; k < 8; k++) begin
      t = umulsh(a, umulsh(y, y, 62), 62);
      if (t > THREE62) t = THREE62;
      y = umulsh(y, THREE62 - t, 63);
    end
    return y;
  endfunction

  function automatic logic [63:0] calc_gain();
    logic [63:0] an2;
    an2 = ONE62;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (2 * i < 64) an2 = an2 + (an2 >> (2 * i));
    end
    return to_f(rsqrt62(an2, udiv(ONE62, 64'd5) * 64'd3));
  endfunction

  function automatic logic [63:0] calc_rad_k91();
    logic [63:0] q;
    logic [63:0] rem;
    q   = udiv(PI62, DEG7_PI);
    rem = umod(PI62, DEG7_PI);
    return (q << 29) + udiv(rem << 29, DEG7_PI);
  endfunction

  function automatic logic [63:0] calc_e2();
    logic [63:0] rem;
    logic [63:0] f62;
    rem = INVF_DEN;
    f62 = '0;
    for (int b = 0; b < 62; b++) begin
      rem = rem << 1;
      f62 = f62 << 1;
      if (rem >= INVF_NUM) begin
        rem    = rem - INVF_NUM;
        f62[0] = 1'b1;
      end
    end
    return umulsh(f62, (64'd2 << 62) - f62, 62);
  endfunction

  localparam atab_t                ATAN_TAB = gen_atan();
  localparam logic signed [CW-1:0] PI_F     = CW'(to_f(PI62));
  localparam logic signed [CW-1:0] TWO_PI_F = CW'(2 * to_f(PI62));
  localparam logic signed [CW-1:0] HALF_F   = CW'(to_f(PI62) / 2);
  localparam logic signed [CW-1:0] GAIN_F   = CW'(calc_gain());
  localparam logic [63:0]          RAD_K91  = calc_rad_k91();
  localparam logic [63:0]          E2_62    = calc_e2();
  localparam logic [63:0]          OME2_62  = ONE62 - E2_62;

endpackage

`default_nettype wire

FILE: rtl/g2e_sincos.sv
// Sine and cosine of an angle in 1e-7 degree: scale, quadrant fold, pipelined CORDIC.
`default_nettype none

module g2e_sincos import g2e_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [31:0]   deg7,
  output logic signed [CW-1:0] sin_o,
  output logic signed [CW-1:0] cos_o
);

  smp_t                 zp_r;
  logic signed [CW-1:0] z2_r;
  logic signed [CW-1:0] cx_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] cz_r [CORDIC_STAGES+1];
  logic                 cn_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] s_r;
  logic signed [CW-1:0] c_r;
  logic signed [CW-1:0] zr_nxt;
  logic                 neg_nxt;

  // fold the angle into [-pi/2, pi/2]
  always_comb begin
    zr_nxt  = z2_r;
    neg_nxt = 1'b0;
    if (zr_nxt > PI_F) zr_nxt = zr_nxt - TWO_PI_F;
    if (zr_nxt < -PI_F) zr_nxt = zr_nxt + TWO_PI_F;
    if (zr_nxt > HALF_F) begin
      zr_nxt  = zr_nxt - PI_F;
      neg_nxt = 1'b1;
    end else if (zr_nxt < -HALF_F) begin
      zr_nxt  = zr_nxt + PI_F;
      neg_nxt = 1'b1;
    end
  end

  // scale to radians, fold, then rotate one stage per register
  always_ff @(posedge clk) begin
    if (en) begin
      zp_r     <= smul_parts(64'(deg7), $signed(RAD_K91));
      z2_r     <= CW'(smul_comb(zp_r, 91 - FRAC_BITS));
      cx_r[0]  <= GAIN_F;
      cy_r[0]  <= '0;
      cz_r[0]  <= zr_nxt;
      cn_r[0]  <= neg_nxt;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cn_r[i+1] <= cn_r[i];
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - $signed(ATAN_TAB[i]);
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + $signed(ATAN_TAB[i]);
        end
      end
      s_r <= cn_r[CORDIC_STAGES] ? -cy_r[CORDIC_STAGES] : cy_r[CORDIC_STAGES];
      c_r <= cn_r[CORDIC_STAGES] ? -cx_r[CORDIC_STAGES] : cx_r[CORDIC_STAGES];
    end
  end

  assign sin_o = s_r;
  assign cos_o = c_r;

endmodule

`default_nettype wire

FILE: rtl/g2e_ecef.sv
// Geodetic point to ECEF in mm Q8: radius of curvature by Newton steps, then scaling.
`default_nettype none

module g2e_ecef import g2e_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [27:0] alt,
  output logic signed [63:0] x,
  output logic signed [63:0] y,
  output logic signed [63:0] z,
  output trig_t              trig
);

  typedef struct packed {
    trig_t                     t;
    logic signed [OUT_W-1:0]   h8;
  } side_t;

  localparam int SIDE_LEN = ECEF_POST;

  logic signed [CW-1:0] s_lat, c_lat, s_lon, c_lon;
  logic signed [27:0]   alt_r  [SC_LAT];
  side_t                side_r [SIDE_LEN];
  side_t                side0;

  mparts_t     s2p_r;
  logic [63:0] s2_r;
  mparts_t     qp_r;
  logic [63:0] qv_r;
  logic [63:0] s2_full;
  logic [63:0] ms;
  logic [63:0] qmul;

  // Newton step registers, six stages per step
  mparts_t     yyp_r [8];
  logic [63:0] yy_r  [8];
  mparts_t     tp_r  [8];
  logic [63:0] w_r   [8];
  mparts_t     wp_r  [8];
  logic [63:0] yo_r  [8];
  logic [63:0] ya_r  [8];
  logic [63:0] yb_r  [8];
  logic [63:0] yc_r  [8];
  logic [63:0] yd_r  [8];
  logic [63:0] aa_r  [8];
  logic [63:0] ab_r  [8];
  logic [63:0] ac_r  [8];
  logic [63:0] ad_r  [8];
  logic [63:0] ae_r  [8];
  logic [63:0] af_r  [8];
  logic [63:0] y_in  [8];
  logic [63:0] a_in  [8];
  logic [63:0] t_cmb [8];

  mparts_t            np_r;
  logic signed [63:0] n8_r;
  smp_t               pp_r;
  mparts_t            zp_r;
  logic signed [63:0] p_r;
  logic signed [63:0] zpre_r;
  smp_t               xp_r, yp_r, zzp_r;
  logic signed [63:0] x_r, y_r, z_r;

  g2e_sincos u_lat (.clk(clk), .en(en), .deg7(lat), .sin_o(s_lat), .cos_o(c_lat));
  g2e_sincos u_lon (.clk(clk), .en(en), .deg7(lon), .sin_o(s_lon), .cos_o(c_lon));

  always_comb begin
    side0.t.s_lat = s_lat;
    side0.t.c_lat = c_lat;
    side0.t.s_lon = s_lon;
    side0.t.c_lon = c_lon;
    side0.h8      = {alt_r[SC_LAT-1], 8'd0};
    ms            = sabs(64'(s_lat)) << (62 - FRAC_BITS);
    s2_full       = mul_comb(s2p_r, 62);
    qmul          = mul_comb(qp_r, 62);
    for (int k = 0; k < 8; k++) begin
      y_in[k]  = (k == 0) ? ONE62 : yo_r[(k == 0) ? 0 : k - 1];
      a_in[k]  = (k == 0) ? qv_r : af_r[(k == 0) ? 0 : k - 1];
      t_cmb[k] = mul_comb(tp_r[k], 62);
    end
  end

  // carry altitude through the sin/cos latency, then the side data alongside
  always_ff @(posedge clk) begin
    if (en) begin
      alt_r[0] <= alt;
      for (int k = 1; k < SC_LAT; k++) alt_r[k] <= alt_r[k-1];
      side_r[0] <= side0;
      for (int k = 1; k < SIDE_LEN; k++) side_r[k] <= side_r[k-1];
    end
  end

  // 1 - e2 sin^2(lat)
  always_ff @(posedge clk) begin
    if (en) begin
      s2p_r <= mul_parts(ms, ms);
      s2_r  <= (s2_full > ONE62) ? ONE62 : s2_full;
      qp_r  <= mul_parts(E2_62, s2_r);
      qv_r  <= ONE62 - qmul;
    end
  end

  // eight Newton steps for the inverse square root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        yyp_r[k] <= mul_parts(y_in[k], y_in[k]);
        ya_r[k]  <= y_in[k];
        aa_r[k]  <= a_in[k];
        yy_r[k]  <= mul_comb(yyp_r[k], 62);
        yb_r[k]  <= ya_r[k];
        ab_r[k]  <= aa_r[k];
        tp_r[k]  <= mul_parts(ab_r[k], yy_r[k]);
        yc_r[k]  <= yb_r[k];
        ac_r[k]  <= ab_r[k];
        w_r[k]   <= THREE62 - ((t_cmb[k] > THREE62) ? THREE62 : t_cmb[k]);
        yd_r[k]  <= yc_r[k];
        ad_r[k]  <= ac_r[k];
        wp_r[k]  <= mul_parts(yd_r[k], w_r[k]);
        ae_r[k]  <= ad_r[k];
        yo_r[k]  <= mul_comb(wp_r[k], 63);
        af_r[k]  <= ae_r[k];
      end
    end
  end

  // radius of curvature, then x, y, z
  always_ff @(posedge clk) begin
    if (en) begin
      np_r   <= mul_parts(A_EARTH_MM, yo_r[7]);
      n8_r   <= $signed(mul_comb(np_r, 54));
      pp_r   <= smul_parts(n8_r + 64'(side_r[53].h8), 64'(side_r[53].t.c_lat));
      zp_r   <= mul_parts(n8_r, OME2_62);
      p_r    <= smul_comb(pp_r, FRAC_BITS);
      zpre_r <= $signed(mul_comb(zp_r, 62));
      xp_r   <= smul_parts(p_r, 64'(side_r[55].t.c_lon));
      yp_r   <= smul_parts(p_r, 64'(side_r[55].t.s_lon));
      zzp_r  <= smul_parts(zpre_r + 64'(side_r[55].h8), 64'(side_r[55].t.s_lat));
      x_r    <= smul_comb(xp_r, FRAC_BITS);
      y_r    <= smul_comb(yp_r, FRAC_BITS);
      z_r    <= smul_comb(zzp_r, FRAC_BITS);
    end
  end

  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
  assign trig = side_r[SIDE_LEN-1].t;

endmodule

`default_nettype wire

FILE: rtl/g2e_rotate.sv
// Difference of two ECEF points rotated into the reference's east, north, up frame.
`default_nettype none

module g2e_rotate import g2e_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [63:0]      px,
  input  logic signed [63:0]      py,
  input  logic signed [63:0]      pz,
  input  logic signed [63:0]      rx,
  input  logic signed [63:0]      ry,
  input  logic signed [63:0]      rz,
  input  trig_t                   rtrig,
  output logic signed [OUT_W-1:0] east,
  output logic signed [OUT_W-1:0] north,
  output logic signed [OUT_W-1:0] up
);

  logic signed [63:0] dx_r, dy_r, dz1_r, dz2_r, dz3_r, dz4_r;
  trig_t              tr1_r, tr2_r, tr3_r, tr4_r;
  smp_t               ea_r, eb_r, ta_r, tb_r;
  logic signed [63:0] mea_r, meb_r, mta_r, mtb_r;
  logic signed [63:0] e4_r, e5_r, e6_r, e7_r, t4_r;
  smp_t               na_r, nb_r, ua_r, ub_r;
  logic signed [63:0] mna_r, mnb_r, mua_r, mub_r;
  logic signed [63:0] n7_r, u7_r;
  logic signed [OUT_W-1:0] east_r, north_r, up_r;

  // Q8 to mm rounding half up, saturated to the output width
  function automatic logic signed [OUT_W-1:0] finish(logic signed [63:0] v8);
    logic signed [63:0] v;
    v = (v8 + 64'sd128) >>> 8;
    if (v > $signed(64'((64'd1 << (OUT_W - 1)) - 1))) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < -$signed(64'd1 << (OUT_W - 1))) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return v[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // difference
      dx_r  <= px - rx;
      dy_r  <= py - ry;
      dz1_r <= pz - rz;
      tr1_r <= rtrig;
      // east and horizontal projection products
      ea_r  <= smul_parts(dy_r, 64'(tr1_r.c_lon));
      eb_r  <= smul_parts(dx_r, 64'(tr1_r.s_lon));
      ta_r  <= smul_parts(dx_r, 64'(tr1_r.c_lon));
      tb_r  <= smul_parts(dy_r, 64'(tr1_r.s_lon));
      dz2_r <= dz1_r;
      tr2_r <= tr1_r;
      mea_r <= smul_comb(ea_r, FRAC_BITS);
      meb_r <= smul_comb(eb_r, FRAC_BITS);
      mta_r <= smul_comb(ta_r, FRAC_BITS);
      mtb_r <= smul_comb(tb_r, FRAC_BITS);
      dz3_r <= dz2_r;
      tr3_r <= tr2_r;
      e4_r  <= mea_r - meb_r;
      t4_r  <= mta_r + mtb_r;
      dz4_r <= dz3_r;
      tr4_r <= tr3_r;
      // north and up products
      na_r  <= smul_parts(dz4_r, 64'(tr4_r.c_lat));
      nb_r  <= smul_parts(t4_r, 64'(tr4_r.s_lat));
      ua_r  <= smul_parts(t4_r, 64'(tr4_r.c_lat));
      ub_r  <= smul_parts(dz4_r, 64'(tr4_r.s_lat));
      e5_r  <= e4_r;
      mna_r <= smul_comb(na_r, FRAC_BITS);
      mnb_r <= smul_comb(nb_r, FRAC_BITS);
      mua_r <= smul_comb(ua_r, FRAC_BITS);
      mub_r <= smul_comb(ub_r, FRAC_BITS);
      e6_r  <= e5_r;
      n7_r  <= mna_r - mnb_r;
      u7_r  <= mua_r + mub_r;
      e7_r  <= e6_r;
      // round to mm
      east_r  <= finish(e7_r);
      north_r <= finish(n7_r);
      up_r    <= finish(u7_r);
    end
  end

  assign east  = east_r;
  assign north = north_r;
  assign up    = up_r;

endmodule

`default_nettype wire

FILE: rtl/geodetic_to_enu.sv
// Top level: WGS84 geodetic point to east, north, up offset from a configured reference.
`default_nettype none

// Converts each point (latitude, longitude in 1e-7 degree, altitude in mm) and the
// configured reference point to ECEF and returns the difference in the reference's
// local east/north/up frame, in mm. One point is accepted per cycle while the output
// is not stalled; the pipeline depth is set by the CORDIC chain, the eight Newton
// steps of the inverse square root and the split 64-bit multiplies. A stall on the
// output holds the whole pipeline. Status 1 flags an input angle out of range, status
// 2 a reference angle out of range; east, north and up are zero then. Write the
// reference registers only while no point is in flight.
module geodetic_to_enu import g2e_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // latitude[31:0], longitude[63:32], altitude[91:64], zero[95:92]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // east[35:0], north[71:36], up[107:72], status[109:108], zero[111:110]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  logic signed [31:0] ref_lat_r, ref_lon_r;
  logic signed [27:0] ref_alt_r;
  logic               v_r  [TOTAL_LAT];
  logic [1:0]         st_r [TOTAL_LAT];
  logic               en;
  logic [1:0]         st_nxt;

  logic signed [31:0] lat, lon;
  logic signed [27:0] alt;
  logic signed [63:0] px, py, pz, rx, ry, rz;
  trig_t              ptrig, rtrig;
  logic signed [OUT_W-1:0] east, north, up;
  logic               err;

  assign lat = in_tdata[31:0];
  assign lon = in_tdata[63:32];
  assign alt = in_tdata[91:64];

  // advance everything together unless the output beat is held
  assign en        = !v_r[TOTAL_LAT-1] || out_tready;
  assign in_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
      ref_alt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_LAT: ref_lat_r <= cfg_data;
        CFG_REF_LON: ref_lon_r <= cfg_data;
        CFG_REF_ALT: ref_alt_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // range check; the input point's error wins
  always_comb begin
    if (lat < LAT_MIN || lat > LAT_MAX || lon < LON_MIN) begin
      st_nxt = STAT_IN_ERR;
    end else if (ref_lat_r < LAT_MIN || ref_lat_r > LAT_MAX || ref_lon_r < LON_MIN) begin
      st_nxt = STAT_REF_ERR;
    end else begin
      st_nxt = STAT_OK;
    end
  end

  // valid bits and status travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TOTAL_LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < TOTAL_LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st_nxt;
      for (int k = 1; k < TOTAL_LAT; k++) st_r[k] <= st_r[k-1];
    end
  end

  g2e_ecef u_pt (
    .clk(clk), .en(en), .lat(lat), .lon(lon), .alt(alt),
    .x(px), .y(py), .z(pz), .trig(ptrig)
  );

  g2e_ecef u_ref (
    .clk(clk), .en(en), .lat(ref_lat_r), .lon(ref_lon_r), .alt(ref_alt_r),
    .x(rx), .y(ry), .z(rz), .trig(rtrig)
  );

  g2e_rotate u_rot (
    .clk(clk), .en(en),
    .px(px), .py(py), .pz(pz), .rx(rx), .ry(ry), .rz(rz),
    .rtrig(rtrig), .east(east), .north(north), .up(up)
  );

  // drop the offsets on an error beat
  assign err        = (st_r[TOTAL_LAT-1] != STAT_OK);
  assign out_tvalid = v_r[TOTAL_LAT-1];
  assign out_tdata  = {2'b00, st_r[TOTAL_LAT-1],
                       err ? {OUT_W{1'b0}} : up,
                       err ? {OUT_W{1'b0}} : north,
                       err ? {OUT_W{1'b0}} : east};

  // the point's own trig values are not needed past the ECEF stage
  logic unused_trig;
  assign unused_trig = ^ptrig;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for geodetic_to_enu: random and directed points checked against a fixed-point ENU predictor.
`default_nettype none

module tb_top;
  import g2e_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] EARTH_A_MM = 64'd6378137000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [27:0] alt;
  } point_t;

  typedef struct packed {
    logic signed [35:0] east;
    logic signed [35:0] north;
    logic signed [35:0] up;
    logic [1:0]         status;
  } enu_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = CFG_REF_LAT;
  logic [31:0]            cfg_data = '0;

  geodetic_to_enu uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor constants and reference mirror
  longint      atan_tab [CORDIC_STAGES];
  longint      pi_q, gain_q, deg_to_rad;
  logic [63:0] e2_q62, one_minus_e2;
  longint      mir_lat = 0, mir_lon = 0, mir_alt = 0;

  point_t pending_points [$];
  enu_t   expected_enu [$];
  int     n_queued = 0, n_accepted = 0, n_errors = 0;
  logic   in_beat = 1'b0;
  bit     quiet = 1'b0;
  int     hold_req = 0, hold_ack = 0, hold_left = 0;

  // unsigned multiply, round to nearest at the shift point
  function automatic logic [63:0] umul_rnd(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (sh != 0) p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    return p[63:0];
  endfunction

  // signed multiply on magnitudes, ties away from zero, saturate
  function automatic longint smul_rnd(longint a, longint b, int sh);
    logic [63:0] r;
    logic        neg;
    neg = (a < 0) != (b < 0);
    r = umul_rnd(a < 0 ? 64'd0 - a : a, b < 0 ? 64'd0 - b : b, sh);
    if (r > 64'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint q62_to_frac(logic [63:0] v);
    return longint'((v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
  endfunction

  // inverse square root by eight Newton steps
  function automatic logic [63:0] inv_sqrt(logic [63:0] a, logic [63:0] y);
    logic [63:0] t;
    for (int k = 0; k < 8; k++) begin
      t = umul_rnd(a, umul_rnd(y, y, 62), 62);
      if (t > 3 * Q62_ONE) t = 3 * Q62_ONE;
      y = umul_rnd(y, 3 * Q62_ONE - t, 63);
    end
    return y;
  endfunction

  // arctangent series with first term p and ratio shift / divisor
  function automatic logic [63:0] atan_series(logic [63:0] p, logic [63:0] div, int sh);
    logic [63:0] s, k, t;
    s = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) s = s - t;
      else s = s + t;
      p = (sh > 0) ? ((sh < 64) ? p >> sh : 64'd0) : p / div;
      k = k + 1;
    end
    return s;
  endfunction

  task automatic build_constants();
    logic [63:0] pi62, an2, f62, rem, q;
    pi62 = 16 * atan_series(Q62_ONE / 5, 25, 0) - 4 * atan_series(Q62_ONE / 239, 239 * 239, 0);
    pi_q = q62_to_frac(pi62);
    atan_tab[0] = q62_to_frac(pi62 >> 2);
    for (int i = 1; i < CORDIC_STAGES; i++)
      atan_tab[i] = q62_to_frac(atan_series(64'd1 << (62 - i), 0, 2 * i));
    an2 = Q62_ONE;
    for (int i = 0; i < CORDIC_STAGES; i++)
      if (2 * i < 64) an2 = an2 + (an2 >> (2 * i));
    gain_q = q62_to_frac(inv_sqrt(an2, Q62_ONE / 5 * 3));
    q = pi62 / 64'd1800000000;
    rem = pi62 % 64'd1800000000;
    deg_to_rad = longint'((q << 29) + (rem << 29) / 64'd1800000000);
    rem = 64'd1000000000;
    f62 = 0;
    for (int b = 0; b < 62; b++) begin
      rem = rem << 1;
      f62 = f62 << 1;
      if (rem >= 64'd298257223563) begin
        rem = rem - 64'd298257223563;
        f62[0] = 1'b1;
      end
    end
    e2_q62 = umul_rnd(f62, (64'd2 << 62) - f62, 62);
    one_minus_e2 = Q62_ONE - e2_q62;
  endtask

  // CORDIC sine and cosine of an angle in 1e-7 degree
  function automatic void cordic_sincos(longint deg7, output longint s, output longint c);
    longint z, x, y, dx, dy, half;
    bit     flip;
    z = smul_rnd(deg7, deg_to_rad, 91 - FRAC_BITS);
    half = pi_q / 2;
    x = gain_q;
    y = 0;
    flip = 0;
    if (z > pi_q) z -= 2 * pi_q;
    if (z < -pi_q) z += 2 * pi_q;
    if (z > half) begin
      z -= pi_q;
      flip = 1;
    end else if (z < -half) begin
      z += pi_q;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // ECEF in mm Q8, plus the trig terms of the point
  function automatic void to_ecef(longint lat, longint lon, longint alt,
                                  output longint ex, output longint ey, output longint ez,
                                  output longint sl, output longint cl,
                                  output longint so, output longint co);
    logic [63:0] ms, s2, qv, r;
    longint      n8, h8, p;
    cordic_sincos(lat, sl, cl);
    cordic_sincos(lon, so, co);
    ms = (sl < 0 ? 64'd0 - sl : sl) << (62 - FRAC_BITS);
    s2 = umul_rnd(ms, ms, 62);
    if (s2 > Q62_ONE) s2 = Q62_ONE;
    qv = Q62_ONE - umul_rnd(e2_q62, s2, 62);
    r = inv_sqrt(qv, Q62_ONE);
    n8 = longint'(umul_rnd(EARTH_A_MM, r, 54));
    h8 = alt * 256;
    p = smul_rnd(n8 + h8, cl, FRAC_BITS);
    ex = smul_rnd(p, co, FRAC_BITS);
    ey = smul_rnd(p, so, FRAC_BITS);
    ez = smul_rnd(longint'(umul_rnd(n8, one_minus_e2, 62)) + h8, sl, FRAC_BITS);
  endfunction

  function automatic logic [35:0] q8_to_mm(longint v8);
    longint v;
    v = (v8 + 128) >>> 8;
    if (v > (64'sd1 <<< 35) - 1) v = (64'sd1 <<< 35) - 1;
    if (v < -(64'sd1 <<< 35)) v = -(64'sd1 <<< 35);
    return v[35:0];
  endfunction

  function automatic bit angles_valid(longint lat, longint lon);
    return lat >= -900000000 && lat <= 900000000 && lon >= -1800000000;
  endfunction

  function automatic enu_t predict_enu(point_t pt);
    enu_t   r;
    longint px, py, pz, rx, ry, rz, s0, c0, s1, c1, rs0, rc0, rs1, rc1;
    longint dx, dy, dz, t;
    r = '0;
    if (!angles_valid(pt.lat, pt.lon)) begin
      r.status = STAT_IN_ERR;
    end else if (!angles_valid(mir_lat, mir_lon)) begin
      r.status = STAT_REF_ERR;
    end else begin
      to_ecef(pt.lat, pt.lon, pt.alt, px, py, pz, s0, c0, s1, c1);
      to_ecef(mir_lat, mir_lon, mir_alt, rx, ry, rz, rs0, rc0, rs1, rc1);
      dx = px - rx;
      dy = py - ry;
      dz = pz - rz;
      t = smul_rnd(dx, rc1, FRAC_BITS) + smul_rnd(dy, rs1, FRAC_BITS);
      r.east  = q8_to_mm(smul_rnd(dy, rc1, FRAC_BITS) - smul_rnd(dx, rs1, FRAC_BITS));
      r.north = q8_to_mm(smul_rnd(dz, rc0, FRAC_BITS) - smul_rnd(t, rs0, FRAC_BITS));
      r.up    = q8_to_mm(smul_rnd(t, rc0, FRAC_BITS) + smul_rnd(dz, rs0, FRAC_BITS));
      r.status = STAT_OK;
    end
    return r;
  endfunction

  // sender: present the next point when the slot is free
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_beat)) begin
      if (pending_points.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
        in_tdata <= {4'd0, pending_points[0].alt, pending_points[0].lon, pending_points[0].lat};
        in_tvalid <= 1'b1;
        void'(pending_points.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (quiet || $urandom_range(99) >= 29);
    end
  end

  // monitor: predict on each input beat, check each output beat
  always @(posedge clk) begin
    enu_t   got, want;
    point_t pt;
    in_beat <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      pt.lat = in_tdata[31:0];
      pt.lon = in_tdata[63:32];
      pt.alt = in_tdata[91:64];
      expected_enu.push_back(predict_enu(pt));
      n_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.east = out_tdata[35:0];
      got.north = out_tdata[71:36];
      got.up = out_tdata[107:72];
      got.status = out_tdata[109:108];
      if (expected_enu.size() == 0) begin
        $display("%0t: unexpected result beat: actual %h", $time, got);
        n_errors++;
      end else begin
        want = expected_enu.pop_front();
        if (got.east !== want.east)
          $display("%0t: east expected %0d actual %0d", $time, want.east, got.east);
        if (got.north !== want.north)
          $display("%0t: north expected %0d actual %0d", $time, want.north, got.north);
        if (got.up !== want.up)
          $display("%0t: up expected %0d actual %0d", $time, want.up, got.up);
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got !== want) n_errors++;
      end
    end
  end

  task automatic add_point(longint lat, longint lon, longint alt);
    point_t pt;
    pt.lat = lat[31:0];
    pt.lon = lon[31:0];
    pt.alt = alt[27:0];
    pending_points.push_back(pt);
    n_queued++;
  endtask

  // mostly valid points; some raw words for bit toggling and range errors
  task automatic add_random(int n);
    longint lat, lon, alt;
    repeat (n) begin
      lat = ($urandom_range(99) < 85) ? longint'($urandom_range(1800000000)) - 900000000
                                      : longint'(int'($urandom));
      lon = ($urandom_range(99) < 90) ? longint'($urandom_range(32'hDFC1_D7FF)) - 1800000000
                                      : longint'(int'($urandom));
      alt = ($urandom_range(99) < 80) ? longint'($urandom_range(101000000)) - 1000000
                                      : longint'($urandom_range(32'h0FFF_FFFF));
      add_point(lat, lon, alt);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_REF_LAT: mir_lat = longint'($signed(v));
      CFG_REF_LON: mir_lon = longint'($signed(v));
      CFG_REF_ALT: mir_alt = longint'($signed(v[27:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ref(longint lat, longint lon, longint alt);
    write_reg(CFG_REF_LAT, lat[31:0]);
    write_reg(CFG_REF_LON, lon[31:0]);
    write_reg(CFG_REF_ALT, alt[31:0]);
  endtask

  // hold until every queued point has come back
  task automatic drain();
    while (n_accepted != n_queued || expected_enu.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    build_constants();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset reference: field extremes and range edges
    add_point(0, 0, 0);
    add_point(900000000, 1800000000, 100000000);
    add_point(-900000000, -1800000000, -1000000);
    add_point(900000001, 0, 0);
    add_point(-900000001, 0, 0);
    add_point(0, -1800000001, 0);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    add_point(-64'sd2147483648, -64'sd2147483648, 0);
    add_point(450000000, 32'sh7FFF_FFFF, 32'sh07FF_FFFF);
    add_point(-450000000, 1234567890, -64'sd134217728);
    add_point(899999999, -1799999999, 12345);
    add_point(0, 900000000, 0);
    add_point(0, -900000000, 0);
    drain();

    // pole/antimeridian extremes of the reference
    set_ref(900000000, -1800000000, -1000000);
    add_point(900000000, -1800000000, -1000000);
    add_point(-900000000, 1800000000, 100000000);
    add_point(900000001, -1800000001, 0);
    quiet = 1;
    add_random(250);
    drain();
    quiet = 0;

    set_ref(-900000000, 32'sh7FFF_FFFF, 100000000);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    add_point(-900000000, 32'sh7FFF_FFFF, 100000000);
    add_random(250);
    drain();

    // long output stall while points keep coming
    set_ref(473977000, 85456000, 408000);
    hold_req++;
    add_random(300);
    drain();

    // reference angle errors, alone and together with point errors
    set_ref(900000001, 0, 0);
    add_point(0, 0, 0);
    add_point(900000001, 0, 0);
    add_random(100);
    drain();
    set_ref(0, -1800000001, 32'hF800_0000);
    add_point(10, 10, 10);
    add_random(100);
    drain();

    // random references with raw altitude words
    repeat (4) begin
      set_ref(longint'($urandom_range(1800000000)) - 900000000,
              longint'($urandom_range(32'hDFC1_D7FF)) - 1800000000,
              longint'($urandom));
      add_random(190);
      drain();
    end

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/g2e_pkg.sv
rtl/g2e_sincos.sv
rtl/g2e_ecef.sv
rtl/g2e_rotate.sv
rtl/geodetic_to_enu.sv
bench/tb_top.sv
